@@ design/ugnq_pkg.sv @@
// Shared constants, payload types and fixed-point helpers for the grid binning block.
`default_nettype none
package ugnq_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int PT_W       = 10;          // point index width
   localparam int CNT_W      = 11;          // point count width, holds MAX_POINTS
   localparam int MAX_AXIS   = 64;
   localparam int AX_W       = 7;           // cells per axis, holds MAX_AXIS
   localparam int CX_W       = 6;           // cell coordinate width
   localparam int CELL_W     = 12;          // flat cell number width
   localparam int CS_DEPTH   = MAX_AXIS * MAX_AXIS + 1;
   localparam int CS_AW      = 13;          // cell slot address, holds cell count
   localparam int FRAC_BITS  = 40;
   localparam int HS_W       = 25;          // half span width
   localparam int PC_W       = CELL_W + 1;  // live flag and cell
   localparam int CSR_AW     = 4;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_FETCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_CELLS_X  = 2'd0,
      REG_CELLS_Y  = 2'd1,
      REG_INV_W    = 2'd2,
      REG_INV_H    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic        active;
      logic [31:0] radius;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_res;
      logic [CNT_W-1:0]  active_count;
      logic [PT_W-1:0]   point_index;
      logic              valid_res;
      logic              done_res;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic [AX_W-1:0] cells_x;
      logic [AX_W-1:0] cells_y;
      logic [31:0]     inv_cell_width;
      logic [31:0]     inv_cell_height;
   } cfg_type;

   function automatic logic [AX_W-1:0] eff_cells(input logic [AX_W-1:0] v);
      logic [AX_W-1:0] r;
      if (v == '0) r = AX_W'(1);
      else if (v > AX_W'(MAX_AXIS)) r = AX_W'(MAX_AXIS);
      else r = v;
      return r;
   endfunction

   // floor of the UQ24.40 product, saturated at the last cell
   function automatic logic [CX_W-1:0] coord(input logic [63:0] prod,
                                            input logic [AX_W-1:0] n);
      logic [23:0]     c;
      logic [CX_W-1:0] r;
      c = prod[63:FRAC_BITS];
      if (c >= 24'(n)) r = CX_W'(n - AX_W'(1));
      else r = c[CX_W-1:0];
      return r;
   endfunction

   // ceiling of the UQ24.40 product
   function automatic logic [HS_W-1:0] half_span(input logic [63:0] prod);
      logic [HS_W-1:0] r;
      r = HS_W'(prod[63:FRAC_BITS]) + HS_W'(prod[FRAC_BITS-1:0] != '0);
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/ugnq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ugnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/ugnq_mul.sv @@
// Shared 32x32 multiplier with a registered 64-bit product.
`default_nettype none
module ugnq_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

@@ design/ugnq_csr.sv @@
// APB-style configuration registers for the grid size and inverse cell sizes.
`default_nettype none
module ugnq_csr
   import ugnq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output cfg_type                cfg
);
   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_hit;
   reg_idx_type idx;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[3:2]);
   assign wr_hit = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         unique case (idx)
            REG_CELLS_X: cfg_in.cells_x         = pwdata[AX_W-1:0];
            REG_CELLS_Y: cfg_in.cells_y         = pwdata[AX_W-1:0];
            REG_INV_W:   cfg_in.inv_cell_width  = pwdata;
            REG_INV_H:   cfg_in.inv_cell_height = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CELLS_X: prdata = 32'(cfg_ff.cells_x);
         REG_CELLS_Y: prdata = 32'(cfg_ff.cells_y);
         REG_INV_W:   prdata = cfg_ff.inv_cell_width;
         REG_INV_H:   prdata = cfg_ff.inv_cell_height;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_x         <= AX_W'(1);
         cfg_ff.cells_y         <= AX_W'(1);
         cfg_ff.inv_cell_width  <= 32'h0100_0000;
         cfg_ff.inv_cell_height <= 32'h0100_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

@@ design/uniform_grid_bin_and_neighbor_query.sv @@
// Load: two passes through the shared multiplier; a load into a full point table is dropped.
// Build: RAM sweeps over the N cells and P loaded points: clear, histogram, prefix sum, scatter.
// Start query: four multiplier passes, then the span set-up and the first cell's bucket bounds;
// fetch: one point index per result, moving on to the next cell while the current bucket is empty.
// One transaction at a time; the next is taken while a result waits in the output register.
// Reset clears control state only; the point, bucket and index RAMs are not cleared.
`default_nettype none
module uniform_grid_bin_and_neighbor_query
   import ugnq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   typedef enum logic [22:0] {
      ST_IDLE = 23'h000001,
      ST_LDX  = 23'h000002,
      ST_LDY  = 23'h000004,
      ST_LDW  = 23'h000008,
      ST_BCLR = 23'h000010,
      ST_HRD  = 23'h000020,
      ST_HCS  = 23'h000040,
      ST_HWR  = 23'h000080,
      ST_PRD  = 23'h000100,
      ST_PWR  = 23'h000200,
      ST_SRD  = 23'h000400,
      ST_SCR  = 23'h000800,
      ST_SWR  = 23'h001000,
      ST_QX   = 23'h002000,
      ST_QY   = 23'h004000,
      ST_QR   = 23'h008000,
      ST_QH   = 23'h010000,
      ST_QS   = 23'h020000,
      ST_WB0  = 23'h040000,
      ST_WB1  = 23'h080000,
      ST_WB2  = 23'h100000,
      ST_FCHK = 23'h200000,
      ST_FDAT = 23'h400000
   } state_type;
   localparam state_type ST_RSP_PLACEHOLDER = ST_IDLE;

   cfg_type cfg;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               rsp_pend_ff, rsp_pend_in;
   logic [CNT_W-1:0]   point_count_ff, point_count_in;
   logic [CNT_W-1:0]   built_count_ff, built_count_in;
   logic [AX_W-1:0]    grid_nx_ff, grid_nx_in, grid_ny_ff, grid_ny_in;
   logic [CS_AW-1:0]   ncell_ff, ncell_in;
   logic [CS_AW-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   acc_ff, acc_in, nact_ff, nact_in;
   logic [CX_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [HS_W-1:0]    hx_ff, hx_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic               busy_ff, busy_in, from_fetch_ff, from_fetch_in;
   logic [AX_W-1:0]    span_w_ff, span_w_in, span_h_ff, span_h_in;
   logic [CX_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [AX_W-1:0]    rx_ff, rx_in, ry_ff, ry_in;
   logic [CNT_W-1:0]   pos_ff, pos_in, end_ff, end_in;
   logic [CS_AW-1:0]   wnext_ff, wnext_in;

   logic               pc_we;
   logic [PT_W-1:0]    pc_waddr, pc_raddr;
   logic [PC_W-1:0]    pc_wdata, pc_rdata;
   logic               cs_we, cur_we;
   logic [CS_AW-1:0]   cs_waddr, cs_raddr, cur_waddr, cur_raddr;
   logic [CNT_W-1:0]   cs_wdata, cs_rdata, cur_wdata, cur_rdata;
   logic               bin_we;
   logic [PT_W-1:0]    bin_waddr, bin_wdata, bin_raddr, bin_rdata;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_prod;

   logic [AX_W-1:0]    nx_eff, ny_eff;
   logic [CX_W-1:0]    cy_ld;
   logic [CELL_W-1:0]  ld_cell;
   logic [CELL_W-1:0]  pc_cell;
   logic               pc_use;
   logic [CNT_W-1:0]   psum;
   logic [HS_W-1:0]    hy;
   logic               all_x, all_y;
   logic [AX_W:0]      tx, ty;
   logic [AX_W-1:0]    gx_sum, gy_sum;
   logic [CX_W-1:0]    gx, gy;
   logic [CS_AW-1:0]   wcell;
   logic               rsp_load;

   ugnq_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   ugnq_mul u_mul (.clock, .op_a(mul_a), .op_b(mul_b), .prod(mul_prod));

   ugnq_ram #(.WIDTH(PC_W), .DEPTH(MAX_POINTS)) u_point_cell (
      .clock, .wr_en(pc_we), .wr_addr(pc_waddr), .wr_data(pc_wdata),
      .rd_addr(pc_raddr), .rd_data(pc_rdata)
   );
   ugnq_ram #(.WIDTH(CNT_W), .DEPTH(CS_DEPTH)) u_cell_start (
      .clock, .wr_en(cs_we), .wr_addr(cs_waddr), .wr_data(cs_wdata),
      .rd_addr(cs_raddr), .rd_data(cs_rdata)
   );
   ugnq_ram #(.WIDTH(CNT_W), .DEPTH(CS_DEPTH)) u_bucket_cursor (
      .clock, .wr_en(cur_we), .wr_addr(cur_waddr), .wr_data(cur_wdata),
      .rd_addr(cur_raddr), .rd_data(cur_rdata)
   );
   ugnq_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_binned_index (
      .clock, .wr_en(bin_we), .wr_addr(bin_waddr), .wr_data(bin_wdata),
      .rd_addr(bin_raddr), .rd_data(bin_rdata)
   );

   assign nx_eff  = eff_cells(cfg.cells_x);
   assign ny_eff  = eff_cells(cfg.cells_y);
   assign cy_ld   = coord(mul_prod, ny_eff);
   assign ld_cell = CELL_W'(CS_AW'(cy_ld) * CS_AW'(nx_eff) + CS_AW'(cx_ff));
   assign pc_cell = pc_rdata[CELL_W-1:0];
   assign pc_use  = pc_rdata[CELL_W] && (CS_AW'(pc_cell) < ncell_ff);
   assign psum    = acc_ff + cs_rdata;

   // query span; when not the whole axis the half span is below half the axis
   assign hy    = half_span(mul_prod);
   assign all_x = ({1'b0, hx_ff, 1'b0} + (HS_W + 2)'(1)) >= (HS_W + 2)'(grid_nx_ff);
   assign all_y = ({1'b0, hy, 1'b0} + (HS_W + 2)'(1)) >= (HS_W + 2)'(grid_ny_ff);
   assign tx    = (AX_W + 1)'(cx_ff) + (AX_W + 1)'(grid_nx_ff) - (AX_W + 1)'(hx_ff[CX_W-1:0]);
   assign ty    = (AX_W + 1)'(cy_ff) + (AX_W + 1)'(grid_ny_ff) - (AX_W + 1)'(hy[CX_W-1:0]);

   // current cell of the wrapped span walk
   assign gx_sum = AX_W'(sx_ff) + rx_ff;
   assign gy_sum = AX_W'(sy_ff) + ry_ff;
   assign gx     = (gx_sum >= grid_nx_ff) ? CX_W'(gx_sum - grid_nx_ff) : gx_sum[CX_W-1:0];
   assign gy     = (gy_sum >= grid_ny_ff) ? CX_W'(gy_sum - grid_ny_ff) : gy_sum[CX_W-1:0];
   assign wcell  = CS_AW'(gy) * CS_AW'(grid_nx_ff) + CS_AW'(gx);

   assign rsp_load = rsp_pend_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      res_in         = res_ff;
      rsp_pend_in    = rsp_pend_ff;
      point_count_in = point_count_ff;
      built_count_in = built_count_ff;
      grid_nx_in     = grid_nx_ff;
      grid_ny_in     = grid_ny_ff;
      ncell_in       = ncell_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      nact_in        = nact_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      hx_in          = hx_ff;
      cell_in        = cell_ff;
      busy_in        = busy_ff;
      from_fetch_in  = from_fetch_ff;
      span_w_in      = span_w_ff;
      span_h_in      = span_h_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      pos_in         = pos_ff;
      end_in         = end_ff;
      wnext_in       = wnext_ff;

      pc_we     = 1'b0;
      pc_waddr  = point_count_ff[PT_W-1:0];
      pc_wdata  = {item_ff.active, ld_cell};
      pc_raddr  = idx_ff[PT_W-1:0];
      cs_we     = 1'b0;
      cs_waddr  = idx_ff;
      cs_wdata  = '0;
      cs_raddr  = idx_ff;
      cur_we    = 1'b0;
      cur_waddr = idx_ff;
      cur_wdata = '0;
      cur_raddr = CS_AW'(pc_cell);
      bin_we    = 1'b0;
      bin_waddr = cur_rdata[PT_W-1:0];
      bin_wdata = idx_ff[PT_W-1:0];
      bin_raddr = pos_ff[PT_W-1:0];
      mul_a     = item_ff.pos_x;
      mul_b     = cfg.inv_cell_width;

      if (rsp_load) begin
         rsp_pend_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !rsp_pend_ff) begin
               item_in = req_data;
               unique case (req_data.cmd)
                  CMD_LOAD: begin
                     if (point_count_ff >= CNT_W'(MAX_POINTS)) begin
                        res_in          = '0;
                        res_in.overflow = 1'b1;
                        rsp_pend_in     = 1'b1;
                     end else begin
                        state_in = ST_LDX;
                     end
                  end
                  CMD_BUILD: begin
                     grid_nx_in = nx_eff;
                     grid_ny_in = ny_eff;
                     ncell_in   = CS_AW'(nx_eff) * CS_AW'(ny_eff);
                     idx_in     = '0;
                     state_in   = ST_BCLR;
                  end
                  CMD_QUERY: state_in = ST_QX;
                  CMD_FETCH: state_in = ST_FCHK;
               endcase
            end
         end
         ST_LDX: state_in = ST_LDY;
         ST_LDY: begin
            cx_in    = coord(mul_prod, nx_eff);
            mul_a    = item_ff.pos_y;
            mul_b    = cfg.inv_cell_height;
            state_in = ST_LDW;
         end
         ST_LDW: begin
            pc_we          = 1'b1;
            point_count_in = point_count_ff + CNT_W'(1);
            res_in         = '0;
            if (item_ff.active) begin
               res_in.cell_res  = ld_cell;
               res_in.valid_res = 1'b1;
            end
            rsp_pend_in = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_BCLR: begin
            // zero cell_start and the cursors over every slot in use
            cs_we  = 1'b1;
            cur_we = 1'b1;
            if (idx_ff == ncell_ff) begin
               idx_in   = '0;
               nact_in  = '0;
               state_in = ST_HRD;
            end else begin
               idx_in = idx_ff + CS_AW'(1);
            end
         end
         ST_HRD: begin
            if (idx_ff == CS_AW'(point_count_ff)) begin
               idx_in   = CS_AW'(1);
               acc_in   = '0;
               state_in = ST_PRD;
            end else begin
               state_in = ST_HCS;
            end
         end
         ST_HCS: begin
            if (pc_use) begin
               cs_raddr = CS_AW'(pc_cell) + CS_AW'(1);
               cell_in  = pc_cell;
               nact_in  = nact_ff + CNT_W'(1);
               state_in = ST_HWR;
            end else begin
               idx_in   = idx_ff + CS_AW'(1);
               state_in = ST_HRD;
            end
         end
         ST_HWR: begin
            cs_we    = 1'b1;
            cs_waddr = CS_AW'(cell_ff) + CS_AW'(1);
            cs_wdata = cs_rdata + CNT_W'(1);
            idx_in   = idx_ff + CS_AW'(1);
            state_in = ST_HRD;
         end
         ST_PRD: begin
            if (idx_ff > ncell_ff) begin
               idx_in   = '0;
               state_in = ST_SRD;
            end else begin
               state_in = ST_PWR;
            end
         end
         ST_PWR: begin
            cs_we     = 1'b1;
            cs_wdata  = psum;
            cur_we    = 1'b1;
            cur_wdata = psum;
            acc_in    = psum;
            idx_in    = idx_ff + CS_AW'(1);
            state_in  = ST_PRD;
         end
         ST_SRD: begin
            if (idx_ff == CS_AW'(point_count_ff)) begin
               built_count_in      = nact_ff;
               point_count_in      = '0;
               busy_in             = 1'b0;
               res_in              = '0;
               res_in.active_count = nact_ff;
               rsp_pend_in         = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               state_in = ST_SCR;
            end
         end
         ST_SCR: begin
            if (pc_use) begin
               cell_in  = pc_cell;
               state_in = ST_SWR;
            end else begin
               idx_in   = idx_ff + CS_AW'(1);
               state_in = ST_SRD;
            end
         end
         ST_SWR: begin
            cur_we    = 1'b1;
            cur_waddr = CS_AW'(cell_ff);
            cur_wdata = cur_rdata + CNT_W'(1);
            bin_we    = !cur_rdata[PT_W];
            idx_in    = idx_ff + CS_AW'(1);
            state_in  = ST_SRD;
         end
         ST_QX: state_in = ST_QY;
         ST_QY: begin
            cx_in    = coord(mul_prod, grid_nx_ff);
            mul_a    = item_ff.pos_y;
            mul_b    = cfg.inv_cell_height;
            state_in = ST_QR;
         end
         ST_QR: begin
            cy_in    = coord(mul_prod, grid_ny_ff);
            mul_a    = item_ff.radius;
            mul_b    = cfg.inv_cell_width;
            state_in = ST_QH;
         end
         ST_QH: begin
            hx_in    = half_span(mul_prod);
            mul_a    = item_ff.radius;
            mul_b    = cfg.inv_cell_height;
            state_in = ST_QS;
         end
         ST_QS: begin
            span_w_in = all_x ? grid_nx_ff : {hx_ff[CX_W-1:0], 1'b1};
            span_h_in = all_y ? grid_ny_ff : {hy[CX_W-1:0], 1'b1};
            if (all_x) sx_in = '0;
            else if (tx >= (AX_W + 1)'(grid_nx_ff)) sx_in = CX_W'(tx - (AX_W + 1)'(grid_nx_ff));
            else sx_in = tx[CX_W-1:0];
            if (all_y) sy_in = '0;
            else if (ty >= (AX_W + 1)'(grid_ny_ff)) sy_in = CX_W'(ty - (AX_W + 1)'(grid_ny_ff));
            else sy_in = ty[CX_W-1:0];
            rx_in         = '0;
            ry_in         = '0;
            pos_in        = '0;
            end_in        = '0;
            from_fetch_in = 1'b0;
            busy_in       = built_count_ff != '0;
            if (built_count_ff != '0) begin
               state_in = ST_WB0;
            end else begin
               res_in      = '0;
               rsp_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WB0: begin
            cs_raddr = wcell;
            wnext_in = wcell + CS_AW'(1);
            state_in = ST_WB1;
         end
         ST_WB1: begin
            pos_in   = cs_rdata;
            cs_raddr = wnext_ff;
            state_in = ST_WB2;
         end
         ST_WB2: begin
            end_in = cs_rdata;
            if (from_fetch_ff) begin
               state_in = ST_FCHK;
            end else begin
               res_in      = '0;
               rsp_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_FCHK: begin
            from_fetch_in = 1'b1;
            if (!busy_ff) begin
               res_in          = '0;
               res_in.done_res = 1'b1;
               rsp_pend_in     = 1'b1;
               state_in        = ST_IDLE;
            end else if (pos_ff < end_ff && !pos_ff[PT_W]) begin
               state_in = ST_FDAT;
            end else if (rx_ff + AX_W'(1) >= span_w_ff) begin
               rx_in = '0;
               if (ry_ff + AX_W'(1) >= span_h_ff) begin
                  busy_in         = 1'b0;
                  res_in          = '0;
                  res_in.done_res = 1'b1;
                  rsp_pend_in     = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  ry_in    = ry_ff + AX_W'(1);
                  state_in = ST_WB0;
               end
            end else begin
               rx_in    = rx_ff + AX_W'(1);
               state_in = ST_WB0;
            end
         end
         ST_FDAT: begin
            res_in             = '0;
            res_in.point_index = bin_rdata;
            res_in.valid_res   = 1'b1;
            pos_in             = pos_ff + CNT_W'(1);
            rsp_pend_in        = 1'b1;
            state_in           = ST_IDLE;
         end
         default: state_in = ST_RSP_PLACEHOLDER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_pend_ff    <= 1'b0;
         point_count_ff <= '0;
         built_count_ff <= '0;
         grid_nx_ff     <= AX_W'(1);
         grid_ny_ff     <= AX_W'(1);
         busy_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_pend_ff    <= rsp_pend_in;
         point_count_ff <= point_count_in;
         built_count_ff <= built_count_in;
         grid_nx_ff     <= grid_nx_in;
         grid_ny_ff     <= grid_ny_in;
         busy_ff        <= busy_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
      item_ff       <= item_in;
      res_ff        <= res_in;
      ncell_ff      <= ncell_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      nact_ff       <= nact_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      hx_ff         <= hx_in;
      cell_ff       <= cell_in;
      from_fetch_ff <= from_fetch_in;
      span_w_ff     <= span_w_in;
      span_h_ff     <= span_h_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      wnext_ff      <= wnext_in;
   end

   // accept only with the pending result slot empty
   assign req_ready = (state_ff == ST_IDLE) && !rsp_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   a_walk_needs_grid: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> built_count_ff != '0)
      else $error("walk open on an empty grid");

   a_result_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && !rsp_pend_ff)
      else $error("pending result not moved to output");

   a_walk_in_span: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && state_ff == ST_FCHK) |-> (rx_ff < span_w_ff && ry_ff < span_h_ff))
      else $error("walk outside its span");
`endif
endmodule
`default_nettype wire
